// ----- rtl/cgi_pkg.sv -----
// ----------------------------------------------------------------------------
// cgi_pkg
// Types and constants shared by the GNSS covariance inflation block.
// ----------------------------------------------------------------------------
package cgi_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ENABLES        = 3'd0;
    localparam logic [2:0] REG_HDOP_GOOD      = 3'd1;
    localparam logic [2:0] REG_HDOP_POOR      = 3'd2;
    localparam logic [2:0] REG_HDOP_SCALE_MAX = 3'd3;
    localparam logic [2:0] REG_SATS_GOOD      = 3'd4;
    localparam logic [2:0] REG_SATS_POOR      = 3'd5;
    localparam logic [2:0] REG_SATS_SCALE_MAX = 3'd6;
    localparam logic [2:0] REG_GATE_SIGMA     = 3'd7;

    localparam logic [15:0] ONE_Q8        = 16'd256;
    localparam logic [15:0] HDOP_MIN_GOOD = 16'd13;
    localparam logic [23:0] SIGMA_MIN     = 24'd3277;
    localparam logic [15:0] GATE_MIN      = 16'd128;

    // Accept-to-strobe distance in cycles, as seen on the ports
    localparam int CGI_LATENCY = 83;

    // Position of a value on a linear ramp
    typedef enum logic [1:0] {
        RAMP_ONE,
        RAMP_FULL,
        RAMP_MID
    } cgi_ramp_t;

    typedef struct packed {
        logic [31:0]        var_x_in;
        logic [31:0]        var_y_in;
        logic [31:0]        var_z_in;
        logic [15:0]        hdop;
        logic [5:0]         num_sats;
        logic signed [31:0] gnss_x;
        logic signed [31:0] gnss_y;
        logic signed [31:0] graph_x;
        logic signed [31:0] graph_y;
        logic               graph_valid;
    } cgi_in_t;

    typedef struct packed {
        logic [31:0] var_x_out;
        logic [31:0] var_y_out;
        logic [31:0] var_z_out;
        logic [15:0] qual_scale;
        logic        gated;
    } cgi_out_t;

    typedef struct packed {
        logic [1:0]  enables;
        logic [15:0] hdop_good;
        logic [15:0] hdop_poor;
        logic [15:0] hdop_scale_max;
        logic [5:0]  sats_good;
        logic [5:0]  sats_poor;
        logic [15:0] sats_scale_max;
        logic [15:0] gate_sigma;
    } cgi_cfg_t;

    // Classified item as handed from front to back
    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] ax;
        logic [31:0] ay;
        logic        halved;
        logic        gate_en;
        cgi_ramp_t   hmode;
        cgi_ramp_t   smode;
        logic [15:0] hmax;
        logic [15:0] smax;
    } cgi_work_t;

    typedef struct packed {
        cgi_work_t   w;
        logic [31:0] hnum;
        logic [15:0] hden;
        logic [21:0] snum;
        logic [5:0]  sden;
    } cgi_item_t;

    // Carried through the root stages
    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [15:0] q;
        logic        halved;
        logic        gate_en;
    } cgi_tail_t;

    // Carried through the gate divider
    typedef struct packed {
        cgi_tail_t t;
        logic      apply;
        logic      big;
    } cgi_gtag_t;

endpackage

// ----- rtl/cgi_div.sv -----
// ----------------------------------------------------------------------------
// cgi_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QB bits; a tag travels alongside.
// ----------------------------------------------------------------------------
module cgi_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QB = 16,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_i,
    output logic          out_valid,
    output logic [QB-1:0] quo,
    output logic [TW-1:0] tag_o
);

    logic          v_reg   [QB];
    logic [NW-1:0] rem_reg [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] q_reg   [QB];
    logic [TW-1:0] tag_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_st
        localparam int B = QB - 1 - k;
        logic             v_in;
        logic [NW-1:0]    r_in;
        logic [DW-1:0]    d_in;
        logic [QB-1:0]    q_in;
        logic [TW-1:0]    t_in;
        logic [NW+QB-1:0] sh;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = num;
            assign d_in = den;
            assign q_in = '0;
            assign t_in = tag_i;
        end
        else
        begin : g_next
            assign v_in = v_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
            assign q_in = q_reg[k-1];
            assign t_in = tag_reg[k-1];
        end

        // trial subtract of the shifted divisor
        assign sh = (NW+QB)'(d_in) << B;
        assign ge = (NW+QB)'(r_in) >= sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? r_in - sh[NW-1:0] : r_in;
            den_reg[k] <= d_in;
            q_reg[k]   <= q_in | (QB'(ge) << B);
            tag_reg[k] <= t_in;
        end
    end

    assign out_valid = v_reg[QB-1];
    assign quo       = q_reg[QB-1];
    assign tag_o     = tag_reg[QB-1];

endmodule

// ----- rtl/cgi_sqrt.sv -----
// ----------------------------------------------------------------------------
// cgi_sqrt
// Pipelined floor square root of a 2*RB bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module cgi_sqrt #(
    parameter int RB = 32,
    parameter int TW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2*RB-1:0] rad,
    input  logic [TW-1:0]   tag_i,
    output logic            out_valid,
    output logic [RB-1:0]   root,
    output logic [TW-1:0]   tag_o
);

    localparam int XW = 2 * RB + 1;

    logic            v_reg    [RB];
    logic [2*RB-1:0] rem_reg  [RB];
    logic [RB-1:0]   root_reg [RB];
    logic [TW-1:0]   tag_reg  [RB];

    for (genvar k = 0; k < RB; k++)
    begin : g_st
        localparam int B = RB - 1 - k;
        logic            v_in;
        logic [2*RB-1:0] r_in;
        logic [RB-1:0]   s_in;
        logic [TW-1:0]   t_in;
        logic [XW-1:0]   trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = rad;
            assign s_in = '0;
            assign t_in = tag_i;
        end
        else
        begin : g_next
            assign v_in = v_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign s_in = root_reg[k-1];
            assign t_in = tag_reg[k-1];
        end

        // (root + 2^B)^2 - root^2
        assign trial = (XW'(s_in) << (B + 1)) | (XW'(1) << (2 * B));
        assign ge    = XW'(r_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? r_in - trial[2*RB-1:0] : r_in;
            root_reg[k] <= s_in | (RB'(ge) << B);
            tag_reg[k]  <= t_in;
        end
    end

    assign out_valid = v_reg[RB-1];
    assign root      = root_reg[RB-1];
    assign tag_o     = tag_reg[RB-1];

endmodule

// ----- rtl/cgi_front.sv -----
// ----------------------------------------------------------------------------
// cgi_front
// Clamps the settings, places HDOP and satellite count on their ramps and
// takes the innovation magnitudes of one fix.
// ----------------------------------------------------------------------------
module cgi_front
    import cgi_pkg::*;
(
    input  cgi_cfg_t  cfg,
    input  cgi_in_t   fix,
    output cgi_item_t item
);

    logic [16:0] hg, hp, h, hdist, hspan;
    logic [15:0] shm, ssm;
    logic [5:0]  sg, sp, ns, sdist, sspan;
    logic [32:0] dx, dy, mx, my;
    logic        big_in;

    always_comb
    begin
        // HDOP ramp
        hg    = (cfg.hdop_good < HDOP_MIN_GOOD) ? 17'(HDOP_MIN_GOOD) : 17'(cfg.hdop_good);
        hp    = (17'(cfg.hdop_poor) < hg + 17'd1) ? hg + 17'd1 : 17'(cfg.hdop_poor);
        shm   = (cfg.hdop_scale_max < ONE_Q8) ? ONE_Q8 : cfg.hdop_scale_max;
        h     = (fix.hdop != '0) ? 17'(fix.hdop) : hp;
        hdist = h - hg;
        hspan = hp - hg;

        // satellite ramp
        sg    = (cfg.sats_good == '0) ? 6'd1 : cfg.sats_good;
        sp    = (cfg.sats_poor > sg - 6'd1) ? sg - 6'd1 : cfg.sats_poor;
        ssm   = (cfg.sats_scale_max < ONE_Q8) ? ONE_Q8 : cfg.sats_scale_max;
        ns    = (fix.num_sats == '0) ? sp : fix.num_sats;
        sdist = sg - ns;
        sspan = sg - sp;

        item.w.hmax = shm;
        item.w.smax = ssm;
        item.hnum   = hdist[15:0] * (shm - ONE_Q8);
        item.hden   = hspan[15:0];
        item.snum   = sdist * (ssm - ONE_Q8);
        item.sden   = sspan;

        if (!cfg.enables[0] || h <= hg)
            item.w.hmode = RAMP_ONE;
        else if (h >= hp)
            item.w.hmode = RAMP_FULL;
        else
            item.w.hmode = RAMP_MID;

        if (!cfg.enables[0] || ns >= sg)
            item.w.smode = RAMP_ONE;
        else if (ns <= sp)
            item.w.smode = RAMP_FULL;
        else
            item.w.smode = RAMP_MID;

        // innovation magnitudes, halved when either reaches 2^31
        dx     = {{1{fix.gnss_x[31]}}, fix.gnss_x} - {{1{fix.graph_x[31]}}, fix.graph_x};
        dy     = {{1{fix.gnss_y[31]}}, fix.gnss_y} - {{1{fix.graph_y[31]}}, fix.graph_y};
        mx     = dx[32] ? 33'd0 - dx : dx;
        my     = dy[32] ? 33'd0 - dy : dy;
        big_in = (mx[32] | mx[31]) | (my[32] | my[31]);

        item.w.ax      = big_in ? mx[32:1] : mx[31:0];
        item.w.ay      = big_in ? my[32:1] : my[31:0];
        item.w.halved  = big_in;
        item.w.gate_en = cfg.enables[1] & fix.graph_valid;
        item.w.vx      = fix.var_x_in;
        item.w.vy      = fix.var_y_in;
        item.w.vz      = fix.var_z_in;
    end

endmodule

// ----- rtl/cgi_queue.sv -----
// ----------------------------------------------------------------------------
// cgi_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module cgi_queue
    import cgi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cgi_item_t wr_item,
    input  logic      pop,
    output logic      rd_valid,
    output cgi_item_t rd_item,
    output logic      full
);

    cgi_item_t   entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_pop;

    assign rd_valid = (count_reg != 2'd0);
    assign full     = (count_reg == 2'd2);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign do_pop   = pop & rd_valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// ----- rtl/cgi_back.sv -----
// ----------------------------------------------------------------------------
// cgi_back
// Carries out one classified item a cycle: ramp divides, quality scaling,
// innovation and sigma roots, gate factor and xy inflation.
// ----------------------------------------------------------------------------
module cgi_back
    import cgi_pkg::*;
#(
    parameter logic [15:0] VMAX = 16'd2560
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cgi_cfg_t  cfg,
    input  logic      in_valid,
    input  cgi_item_t item,
    output logic      done,
    output cgi_out_t  result
);

    // ---------------- ramp divides ----------------
    logic        dh_v;
    logic [15:0] hq, sq;
    logic [$bits(cgi_work_t)-1:0] dh_tag;
    cgi_work_t   dw;

    cgi_div #(.NW(32), .DW(16), .QB(16), .TW($bits(cgi_work_t))) u_div_h (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .num(item.hnum),
        .den(item.hden), .tag_i(item.w), .out_valid(dh_v), .quo(hq), .tag_o(dh_tag)
    );

    cgi_div #(.NW(32), .DW(16), .QB(16), .TW(1)) u_div_s (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .num(32'(item.snum)),
        .den(16'(item.sden)), .tag_i(1'b0), .out_valid(), .quo(sq), .tag_o()
    );

    assign dw = cgi_work_t'(dh_tag);

    // ---------------- stage 1: ramp scales and squares ----------------
    logic [15:0] hs, ss;
    logic        s1_v_reg;
    cgi_work_t   s1_w_reg;
    logic [31:0] s1_q0_reg;
    logic [63:0] s1_sqx_reg, s1_sqy_reg;

    always_comb
    begin
        case (dw.hmode)
            RAMP_ONE:  hs = ONE_Q8;
            RAMP_FULL: hs = dw.hmax;
            default:   hs = ONE_Q8 + hq;
        endcase
        case (dw.smode)
            RAMP_ONE:  ss = ONE_Q8;
            RAMP_FULL: ss = dw.smax;
            default:   ss = ONE_Q8 + sq;
        endcase
    end

    always_ff @(posedge clk)
    begin
        s1_w_reg   <= dw;
        s1_q0_reg  <= hs * ss;
        s1_sqx_reg <= 64'(dw.ax) * 64'(dw.ax);
        s1_sqy_reg <= 64'(dw.ay) * 64'(dw.ay);
    end

    // ---------------- stage 2: quality scale, squared sum ----------------
    logic        s2_v_reg;
    cgi_work_t   s2_w_reg;
    logic [15:0] s2_q_reg;
    logic [63:0] s2_ssum_reg;

    always_ff @(posedge clk)
    begin
        s2_w_reg    <= s1_w_reg;
        s2_q_reg    <= (s1_q0_reg[31:24] != '0) ? 16'hFFFF : s1_q0_reg[23:8];
        s2_ssum_reg <= s1_sqx_reg + s1_sqy_reg;
    end

    // ---------------- stage 3: variance products ----------------
    logic        s3_v_reg;
    cgi_work_t   s3_w_reg;
    logic [15:0] s3_q_reg;
    logic [63:0] s3_ssum_reg;
    logic [47:0] s3_px_reg, s3_py_reg, s3_pz_reg;

    always_ff @(posedge clk)
    begin
        s3_w_reg    <= s2_w_reg;
        s3_q_reg    <= s2_q_reg;
        s3_ssum_reg <= s2_ssum_reg;
        s3_px_reg   <= s2_w_reg.vx * s2_q_reg;
        s3_py_reg   <= s2_w_reg.vy * s2_q_reg;
        s3_pz_reg   <= s2_w_reg.vz * s2_q_reg;
    end

    // ---------------- stage 4: saturate scaled variances ----------------
    function automatic logic [31:0] sat_shr8(input logic [47:0] p);
        return (p[47:40] != '0) ? 32'hFFFF_FFFF : p[39:8];
    endfunction

    logic        s4_v_reg;
    cgi_tail_t   s4_t_reg;
    logic [63:0] s4_ssum_reg;
    logic        scl;
    logic [32:0] vsum;
    logic [47:0] sig_rad;

    assign scl = s3_q_reg > ONE_Q8;

    always_ff @(posedge clk)
    begin
        s4_t_reg.vx      <= scl ? sat_shr8(s3_px_reg) : s3_w_reg.vx;
        s4_t_reg.vy      <= scl ? sat_shr8(s3_py_reg) : s3_w_reg.vy;
        s4_t_reg.vz      <= scl ? sat_shr8(s3_pz_reg) : s3_w_reg.vz;
        s4_t_reg.q       <= s3_q_reg;
        s4_t_reg.halved  <= s3_w_reg.halved;
        s4_t_reg.gate_en <= s3_w_reg.gate_en;
        s4_ssum_reg      <= s3_ssum_reg;
    end

    assign vsum    = 33'(s4_t_reg.vx) + 33'(s4_t_reg.vy);
    assign sig_rad = {vsum[32:1], 16'h0000};

    // ---------------- innovation and sigma roots ----------------
    logic        rt_v;
    logic [31:0] r_inn, r_sig;
    logic [$bits(cgi_tail_t)-1:0] rt_tag;
    cgi_tail_t   rt;

    cgi_sqrt #(.RB(32), .TW(1)) u_sqrt_i (
        .clk(clk), .rst_n(rst_n), .in_valid(s4_v_reg), .rad(s4_ssum_reg),
        .tag_i(1'b0), .out_valid(), .root(r_inn), .tag_o()
    );

    cgi_sqrt #(.RB(32), .TW($bits(cgi_tail_t))) u_sqrt_s (
        .clk(clk), .rst_n(rst_n), .in_valid(s4_v_reg), .rad(64'(sig_rad)),
        .tag_i(s4_t_reg), .out_valid(rt_v), .root(r_sig), .tag_o(rt_tag)
    );

    assign rt = cgi_tail_t'(rt_tag);

    // ---------------- stage 6: threshold product ----------------
    logic        s6_v_reg;
    cgi_tail_t   s6_t_reg;
    logic [32:0] s6_innov_reg;
    logic [23:0] s6_sigma_reg;
    logic [39:0] s6_thp_reg;
    logic [23:0] sigma;
    logic [15:0] gate;

    assign sigma = (r_sig[23:0] < SIGMA_MIN) ? SIGMA_MIN : r_sig[23:0];
    assign gate  = (cfg.gate_sigma < GATE_MIN) ? GATE_MIN : cfg.gate_sigma;

    always_ff @(posedge clk)
    begin
        s6_t_reg     <= rt;
        s6_innov_reg <= rt.halved ? {r_inn, 1'b0} : {1'b0, r_inn};
        s6_sigma_reg <= sigma;
        s6_thp_reg   <= gate * sigma;
    end

    // ---------------- stage 7: gate compare ----------------
    logic        s7_v_reg;
    cgi_gtag_t   s7_g_reg;
    logic [32:0] s7_diff_reg;
    logic [23:0] s7_sigma_reg;
    logic [32:0] thr;
    logic [32:0] diff;

    assign thr  = {1'b0, s6_thp_reg[39:8]};
    assign diff = s6_innov_reg - thr;

    always_ff @(posedge clk)
    begin
        s7_g_reg.t     <= s6_t_reg;
        s7_g_reg.apply <= s6_t_reg.gate_en & (s6_innov_reg > thr);
        s7_g_reg.big   <= diff >= {1'b0, s6_sigma_reg, 8'h00};
        s7_diff_reg    <= diff;
        s7_sigma_reg   <= s6_sigma_reg;
    end

    // ---------------- relative innovation divide ----------------
    logic        dr_v;
    logic [23:0] rel;
    logic [$bits(cgi_gtag_t)-1:0] dr_tag;
    cgi_gtag_t   dg;

    cgi_div #(.NW(49), .DW(24), .QB(24), .TW($bits(cgi_gtag_t))) u_div_r (
        .clk(clk), .rst_n(rst_n), .in_valid(s7_v_reg), .num({s7_diff_reg, 16'h0000}),
        .den(s7_sigma_reg), .tag_i(s7_g_reg), .out_valid(dr_v), .quo(rel), .tag_o(dr_tag)
    );

    assign dg = cgi_gtag_t'(dr_tag);

    // ---------------- stage 8: rel squared ----------------
    logic        s8_v_reg;
    cgi_gtag_t   s8_g_reg;
    logic [47:0] s8_rel2_reg;

    always_ff @(posedge clk)
    begin
        s8_g_reg    <= dg;
        s8_rel2_reg <= rel * rel;
    end

    // ---------------- stage 9: gate factor ----------------
    logic        s9_v_reg;
    cgi_gtag_t   s9_g_reg;
    logic [15:0] s9_m_reg;
    logic [24:0] msum;

    assign msum = 25'(ONE_Q8) + 25'(s8_rel2_reg[47:24]);

    always_ff @(posedge clk)
    begin
        s9_g_reg <= s8_g_reg;
        if (s8_g_reg.big || msum > 25'(VMAX))
            s9_m_reg <= VMAX;
        else
            s9_m_reg <= msum[15:0];
    end

    // ---------------- stage 10: xy products ----------------
    logic        s10_v_reg;
    cgi_gtag_t   s10_g_reg;
    logic [47:0] s10_px_reg, s10_py_reg;

    always_ff @(posedge clk)
    begin
        s10_g_reg  <= s9_g_reg;
        s10_px_reg <= s9_g_reg.t.vx * s9_m_reg;
        s10_py_reg <= s9_g_reg.t.vy * s9_m_reg;
    end

    // ---------------- stage 11: result register ----------------
    cgi_out_t result_reg;
    logic     done_reg;

    always_ff @(posedge clk)
    begin
        result_reg.var_x_out  <= s10_g_reg.apply ? sat_shr8(s10_px_reg) : s10_g_reg.t.vx;
        result_reg.var_y_out  <= s10_g_reg.apply ? sat_shr8(s10_py_reg) : s10_g_reg.t.vy;
        result_reg.var_z_out  <= s10_g_reg.t.vz;
        result_reg.qual_scale <= s10_g_reg.t.q;
        result_reg.gated      <= s10_g_reg.apply;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= dh_v;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s6_v_reg  <= rt_v;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= dr_v;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
            done_reg  <= s10_v_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/gnss_covariance_inflation.sv -----
// ----------------------------------------------------------------------------
// gnss_covariance_inflation
// Inflates GNSS position variances by fix quality and by horizontal
// innovation against the graph estimate.
// ----------------------------------------------------------------------------
//  channel   | signals                          | direction | transfer
//  ----------+----------------------------------+-----------+--------------------
//  fix       | start, busy, fix                 | in        | start & !busy
//  result    | done, result                     | out       | done, one cycle
//  config    | psel penable pwrite paddr pwdata | in/out    | APB, pready tied 1
//
//  One item enters per cycle while busy is low; each result passes the
//  queue and the pipelined divide and square-root units: two 16-stage ramp
//  dividers, 32-stage roots and a 24-stage divider for the gate.
//  Reset clears all valid bits and restores the register defaults.
//  The receiver cannot stall; busy only rises if the front queue fills.
// ----------------------------------------------------------------------------
module gnss_covariance_inflation
    import cgi_pkg::*;
#(
    parameter int CONSIST_SCALE_MAX = 2560
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cgi_in_t     fix,
    output logic        done,
    output cgi_out_t    result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [15:0] VMAX =
        (CONSIST_SCALE_MAX < 256) ? 16'd256 : 16'(CONSIST_SCALE_MAX);

    cgi_cfg_t  cfg_reg;
    cgi_item_t f_item, q_item;
    logic      q_valid, q_full;
    logic      wr_en;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enables        <= 2'd0;
            cfg_reg.hdop_good      <= 16'd256;
            cfg_reg.hdop_poor      <= 16'd1280;
            cfg_reg.hdop_scale_max <= 16'd2560;
            cfg_reg.sats_good      <= 6'd8;
            cfg_reg.sats_poor      <= 6'd4;
            cfg_reg.sats_scale_max <= 16'd2560;
            cfg_reg.gate_sigma     <= 16'd768;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_ENABLES:        cfg_reg.enables        <= pwdata[1:0];
                REG_HDOP_GOOD:      cfg_reg.hdop_good      <= pwdata[15:0];
                REG_HDOP_POOR:      cfg_reg.hdop_poor      <= pwdata[15:0];
                REG_HDOP_SCALE_MAX: cfg_reg.hdop_scale_max <= pwdata[15:0];
                REG_SATS_GOOD:      cfg_reg.sats_good      <= pwdata[5:0];
                REG_SATS_POOR:      cfg_reg.sats_poor      <= pwdata[5:0];
                REG_SATS_SCALE_MAX: cfg_reg.sats_scale_max <= pwdata[15:0];
                REG_GATE_SIGMA:     cfg_reg.gate_sigma     <= pwdata[15:0];
                default:            cfg_reg.enables        <= cfg_reg.enables;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[4:2])
            REG_ENABLES:        prdata = 32'(cfg_reg.enables);
            REG_HDOP_GOOD:      prdata = 32'(cfg_reg.hdop_good);
            REG_HDOP_POOR:      prdata = 32'(cfg_reg.hdop_poor);
            REG_HDOP_SCALE_MAX: prdata = 32'(cfg_reg.hdop_scale_max);
            REG_SATS_GOOD:      prdata = 32'(cfg_reg.sats_good);
            REG_SATS_POOR:      prdata = 32'(cfg_reg.sats_poor);
            REG_SATS_SCALE_MAX: prdata = 32'(cfg_reg.sats_scale_max);
            REG_GATE_SIGMA:     prdata = 32'(cfg_reg.gate_sigma);
            default:            prdata = 32'd0;
        endcase
    end

    assign busy = q_full;

    cgi_front u_front (
        .cfg(cfg_reg), .fix(fix), .item(f_item)
    );

    cgi_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(start & ~q_full), .wr_item(f_item),
        .pop(1'b1), .rd_valid(q_valid), .rd_item(q_item), .full(q_full)
    );

    cgi_back #(.VMAX(VMAX)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .in_valid(q_valid),
        .item(q_item), .done(done), .result(result)
    );

endmodule

// ----- rtl/cgi_checker.sv -----
// ----------------------------------------------------------------------------
// cgi_checker
// Port-level checks on the covariance inflation block.
// ----------------------------------------------------------------------------
module cgi_checker
    import cgi_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input cgi_out_t result
);

    // every accepted item gives a result
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##CGI_LATENCY done)
        else $error("accepted item gave no result");

    // no result without an accepted item
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, CGI_LATENCY))
        else $error("result without an item");

    // the applied scale never drops below one
    a_scale_min: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.qual_scale >= ONE_Q8))
        else $error("quality scale below one");

endmodule

bind gnss_covariance_inflation cgi_checker u_cgi_checker (.*);
